// File: hdl/spiral_matrix_reorder_defines.svh
// ----------------------------------------------------------------------------
// spiral matrix reorder assertion macros
// shared concurrent assertion forms, clocked on a rising edge with an
// active-low reset that disables the check
// ----------------------------------------------------------------------------
`ifndef SPIRAL_MATRIX_REORDER_DEFINES_SVH
`define SPIRAL_MATRIX_REORDER_DEFINES_SVH

// same-cycle implication
`define SMR_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMR_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// shared constants, types and helpers of the spiral matrix reorder block
// ----------------------------------------------------------------------------
package smr_pkg;

	localparam int MAX_ROWS = 8;
	localparam int MAX_COLS = 8;
	localparam int DATA_W   = 32;
	localparam int DIM_W    = 4;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = 7;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int IDX_W    = 1;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	// walk phase of the spiral address generator
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TOP,
		PH_RIGHT,
		PH_BOTTOM,
		PH_LEFT
	} phase_t;

	// read request from the walker to the store
	typedef struct packed {
		logic              valid;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	// force a dimension into 1..maxv
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > maxv) r = maxv;
		else r = v;
		return r;
	endfunction

endpackage

// File: hdl/spiral_matrix_reorder.sv
// ----------------------------------------------------------------------------
// spiral_matrix_reorder
// loads a matrix in row-major order and plays it back in clockwise spiral
// order once the last element is in
// ----------------------------------------------------------------------------
//  channel   dir  signals                         handshake
//  element   in   element_value                   start && !busy
//  result    out  spiral_value, run_last          strobe, one cycle, no stall
//  config    in   cfg_index, cfg_data             cfg_we
//
//  a load beat writes one store entry
//  the beat that completes the matrix starts a run of rows*cols store reads, one
//  per cycle from the spiral walker; results follow each read in the next cycle
//  (registered ram read), and busy is high for the whole walk after that beat
//  reset clears the load count, the walker and the strobe; config resets to 8x8
//  the result side cannot stall, so nothing is buffered past the ram output
// ----------------------------------------------------------------------------
`include "spiral_matrix_reorder_defines.svh"

module spiral_matrix_reorder import smr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] element_value,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] spiral_value,
	output logic                     run_last,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DIM_W-1:0]         cfg_data
);

	logic [DIM_W-1:0]  row_count_q, column_count_q;
	logic [DIM_W-1:0]  rows, cols;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  loaded_count_q, loaded_next;
	logic              accept, complete;
	logic              walk_active;
	rd_req_t           rd;
	logic              valid_s1, last_s1;
	logic [DATA_W-1:0] rdata;

	// clamped dimensions and element count of the current configuration
	assign rows  = clamp_dim(row_count_q, DIM_W'(MAX_ROWS));
	assign cols  = clamp_dim(column_count_q, DIM_W'(MAX_COLS));
	assign total = CNT_W'(rows) * CNT_W'(cols);

	assign busy        = walk_active;
	assign accept      = start && !busy;
	assign loaded_next = loaded_count_q + CNT_W'(1);
	// a count past the total (dimensions shrunk mid-load) also completes
	assign complete    = accept && (loaded_next >= total);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= DIM_W'(MAX_ROWS);
			column_count_q <= DIM_W'(MAX_COLS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// load counter, back to zero when the run starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_count_q <= '0;
		end else if (accept) begin
			loaded_count_q <= complete ? '0 : loaded_next;
		end
	end

	// matrix store: load beats write, walker reads
	smr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (accept),
		.waddr(loaded_count_q[ADDR_W-1:0]),
		.wdata($unsigned(element_value)),
		.re   (rd.valid),
		.raddr(rd.addr),
		.rdata(rdata)
	);

	// spiral address generator, started by the completing beat
	smr_walker u_walker (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (complete),
		.rows  (rows),
		.cols  (cols),
		.total (total),
		.active(walk_active),
		.rd    (rd)
	);

	// result marks are registered alongside the ram read so they line up with its data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd.valid;
			last_s1  <= rd.last;
		end
	end

	assign strobe       = valid_s1;
	assign run_last     = valid_s1 && last_s1;
	assign spiral_value = $signed(rdata);

	// completing beat always hands over to the walker
	`SMR_ASSERT_NEXT(a_run_starts, clk, arst_n, complete, walk_active, "run did not start")
	// nothing follows the final result of a run
	`SMR_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe && run_last, !strobe, "result after last")
	// the load count stays cleared while the walk runs
	`SMR_ASSERT_NOW(a_cnt_clear, clk, arst_n, walk_active, loaded_count_q == '0, "count not clear")
	// walker stops right after issuing its last read
	`SMR_ASSERT_NEXT(a_walk_stop, clk, arst_n, rd.valid && rd.last, !walk_active, "walker overran")

endmodule

// File: hdl/smr_ram.sv
// ----------------------------------------------------------------------------
// smr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module smr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/smr_walker.sv
// ----------------------------------------------------------------------------
// smr_walker
// spiral address generator: one store read address per cycle, clockwise
// from the top left, shrinking the bounds after each side
// ----------------------------------------------------------------------------
module smr_walker import smr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIM_W-1:0] rows,
	input  logic [DIM_W-1:0] cols,
	input  logic [CNT_W-1:0] total,
	output logic             active,
	output rd_req_t          rd
);

	phase_t           phase_q, phase_d;
	logic [ROW_W-1:0] top_q, bot_q, r_q;
	logic [COL_W-1:0] lft_q, rgt_q, c_q;
	logic [DIM_W-1:0] cols_q;
	logic [CNT_W-1:0] total_q, cnt_q;
	logic             last;
	logic             side_end;

	assign last = (cnt_q + CNT_W'(1)) == total_q;

	// end of the current side
	always_comb begin
		unique case (phase_q)
			PH_TOP:    side_end = (c_q == rgt_q);
			PH_RIGHT:  side_end = (r_q == bot_q);
			PH_BOTTOM: side_end = (c_q == lft_q);
			PH_LEFT:   side_end = (r_q == top_q);
			default:   side_end = 1'b0;
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE:   if (go) phase_d = PH_TOP;
			PH_TOP:    if (last) phase_d = PH_IDLE; else if (side_end) phase_d = PH_RIGHT;
			PH_RIGHT:  if (last) phase_d = PH_IDLE; else if (side_end) phase_d = PH_BOTTOM;
			PH_BOTTOM: if (last) phase_d = PH_IDLE; else if (side_end) phase_d = PH_LEFT;
			PH_LEFT:   if (last) phase_d = PH_IDLE; else if (side_end) phase_d = PH_TOP;
			default:   phase_d = PH_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		active   = (phase_q != PH_IDLE);
		rd.valid = active;
		rd.last  = active && last;
		rd.addr  = ADDR_W'(r_q) * ADDR_W'(cols_q) + ADDR_W'(c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE) begin
			top_q   <= '0;
			bot_q   <= ROW_W'(rows - DIM_W'(1));
			lft_q   <= '0;
			rgt_q   <= COL_W'(cols - DIM_W'(1));
			r_q     <= '0;
			c_q     <= '0;
			cnt_q   <= '0;
			cols_q  <= cols;
			total_q <= total;
		end else begin
			cnt_q <= cnt_q + CNT_W'(1);
			unique case (phase_q)
				PH_TOP: begin
					if (side_end) begin
						top_q <= top_q + ROW_W'(1);
						r_q   <= top_q + ROW_W'(1);
					end else begin
						c_q <= c_q + COL_W'(1);
					end
				end
				PH_RIGHT: begin
					if (side_end) begin
						rgt_q <= rgt_q - COL_W'(1);
						c_q   <= rgt_q - COL_W'(1);
					end else begin
						r_q <= r_q + ROW_W'(1);
					end
				end
				PH_BOTTOM: begin
					if (side_end) begin
						bot_q <= bot_q - ROW_W'(1);
						r_q   <= bot_q - ROW_W'(1);
					end else begin
						c_q <= c_q - COL_W'(1);
					end
				end
				default: begin
					if (side_end) begin
						lft_q <= lft_q + COL_W'(1);
						c_q   <= lft_q + COL_W'(1);
					end else begin
						r_q <= r_q - ROW_W'(1);
					end
				end
			endcase
		end
	end

endmodule
